FILE: rtl/core/bbls_pkg.sv
package bbls_pkg;

  localparam int COORD_BITS    = 24;
  localparam int AREA_BITS     = 2 * COORD_BITS + 3;
  localparam int PROD_BITS     = 2 * COORD_BITS;
  localparam int IN_DATA_BITS  = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((7 * COORD_BITS + AREA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - 7 * COORD_BITS - AREA_BITS;
  localparam int AXIS_BITS     = 2;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS-1:0] ext_t;
  typedef logic [PROD_BITS-1:0] prod_t;
  typedef logic [AREA_BITS-1:0] area_t;

  typedef enum logic [AXIS_BITS-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t min_z;
    coord_t max_z;
  } bounds_t;

endpackage

FILE: rtl/core/bbls_front.sv
module bbls_front
  import bbls_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [IN_DATA_BITS-1:0] in_tdata,  // x_coord, y_coord, z_coord
  input  logic                    in_tlast,  // last_vertex
  output logic                    push_valid,
  input  logic                    push_ready,
  output bounds_t                 push_data
);

  coord_t  x, y, z;
  logic    accept;
  logic    started_r, started_nxt;
  bounds_t box_r, box_nxt;

  assign x = coord_t'(in_tdata[COORD_BITS-1:0]);
  assign y = coord_t'(in_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign z = coord_t'(in_tdata[3*COORD_BITS-1:2*COORD_BITS]);

  assign in_tready = push_ready;
  assign accept    = in_tvalid && push_ready;

  always_comb begin
    box_nxt = box_r;
    if (!started_r) begin
      box_nxt.min_x = x;
      box_nxt.max_x = x;
      box_nxt.min_y = y;
      box_nxt.max_y = y;
      box_nxt.min_z = z;
      box_nxt.max_z = z;
    end else begin
      if (x < box_r.min_x) box_nxt.min_x = x;
      if (x > box_r.max_x) box_nxt.max_x = x;
      if (y < box_r.min_y) box_nxt.min_y = y;
      if (y > box_r.max_y) box_nxt.max_y = y;
      if (z < box_r.min_z) box_nxt.min_z = z;
      if (z > box_r.max_z) box_nxt.max_z = z;
    end
  end

  assign started_nxt = accept ? !in_tlast : started_r;
  assign push_valid  = accept && in_tlast;
  assign push_data   = box_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      box_r <= box_nxt;
    end
  end

endmodule

FILE: rtl/core/bbls_queue.sv
module bbls_queue
  import bbls_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  bounds_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output bounds_t pop_data
);

  bounds_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]  count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];

  assign do_push = push_valid && push_ready;
  assign do_pop  = pop_valid && pop_ready;

  assign wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
  assign rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/bbls_back.sv
module bbls_back
  import bbls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  output logic                     pop_ready,
  input  bounds_t                  pop_data,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // min_x, max_x, min_y, max_y, min_z, max_z, split_position, surface_area
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic [AXIS_BITS-1:0]     out_tuser   // long_axis
);

  logic    advance;

  // stage 1: extents
  logic    s1_valid_r;
  bounds_t s1_box_r;
  ext_t    s1_dx_r, s1_dy_r, s1_dz_r;
  ext_t    s1_dx_nxt, s1_dy_nxt, s1_dz_nxt;

  // stage 2: axis, midpoint, products
  logic    s2_valid_r;
  bounds_t s2_box_r;
  axis_t   s2_axis_r, s2_axis_nxt;
  coord_t  s2_split_r, s2_split_nxt;
  prod_t   s2_pxy_r, s2_pxz_r, s2_pyz_r;
  logic signed [COORD_BITS:0] mid_sum;

  // stage 3: area, output register
  logic    s3_valid_r;
  bounds_t s3_box_r;
  axis_t   s3_axis_r;
  coord_t  s3_split_r;
  area_t   s3_area_r, s3_area_nxt;
  logic [AREA_BITS-2:0] prod_sum;

  assign advance   = !s3_valid_r || out_tready;
  assign pop_ready = advance;

  assign s1_dx_nxt = ext_t'(pop_data.max_x - pop_data.min_x);
  assign s1_dy_nxt = ext_t'(pop_data.max_y - pop_data.min_y);
  assign s1_dz_nxt = ext_t'(pop_data.max_z - pop_data.min_z);

  always_comb begin
    mid_sum = '0;
    if (s1_dx_r >= s1_dy_r && s1_dx_r >= s1_dz_r) begin
      s2_axis_nxt = AXIS_X;
      mid_sum     = {s1_box_r.min_x[COORD_BITS-1], s1_box_r.min_x}
                  + {s1_box_r.max_x[COORD_BITS-1], s1_box_r.max_x};
    end else if (s1_dy_r >= s1_dz_r) begin
      s2_axis_nxt = AXIS_Y;
      mid_sum     = {s1_box_r.min_y[COORD_BITS-1], s1_box_r.min_y}
                  + {s1_box_r.max_y[COORD_BITS-1], s1_box_r.max_y};
    end else begin
      s2_axis_nxt = AXIS_Z;
      mid_sum     = {s1_box_r.min_z[COORD_BITS-1], s1_box_r.min_z}
                  + {s1_box_r.max_z[COORD_BITS-1], s1_box_r.max_z};
    end
    s2_split_nxt = coord_t'(mid_sum[COORD_BITS:1]);
  end

  assign prod_sum = (AREA_BITS-1)'(s2_pxy_r) + (AREA_BITS-1)'(s2_pxz_r)
                  + (AREA_BITS-1)'(s2_pyz_r);
  assign s3_area_nxt = {prod_sum, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= pop_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_box_r   <= pop_data;
      s1_dx_r    <= s1_dx_nxt;
      s1_dy_r    <= s1_dy_nxt;
      s1_dz_r    <= s1_dz_nxt;
      s2_box_r   <= s1_box_r;
      s2_axis_r  <= s2_axis_nxt;
      s2_split_r <= s2_split_nxt;
      s2_pxy_r   <= s1_dx_r * s1_dy_r;
      s2_pxz_r   <= s1_dx_r * s1_dz_r;
      s2_pyz_r   <= s1_dy_r * s1_dz_r;
      s3_box_r   <= s2_box_r;
      s3_axis_r  <= s2_axis_r;
      s3_split_r <= s2_split_r;
      s3_area_r  <= s3_area_nxt;
    end
  end

  assign out_tvalid = s3_valid_r;
  assign out_tuser  = s3_axis_r;
  assign out_tdata  = {{OUT_PAD_BITS{1'b0}}, s3_area_r, s3_split_r,
                       s3_box_r.max_z, s3_box_r.min_z,
                       s3_box_r.max_y, s3_box_r.min_y,
                       s3_box_r.max_x, s3_box_r.min_x};

endmodule

FILE: rtl/core/bounding_box_longest_axis_split_top.sv
// path: a finished set's bounds pass the queue, then stages s1, s2 and s3
// throughput: one vertex/result per cycle unless stalled, set by the min/max update
// a 4-entry queue holds finished bounds while the 3-stage area pipeline is stalled
// reset: rst_n synchronous active low clears the set-open flag, queue and valid bits
module bounding_box_longest_axis_split_top
  import bbls_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // x_coord, y_coord, z_coord
  input  logic                     in_tlast,   // last_vertex
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // min_x, max_x, min_y, max_y, min_z, max_z, split_position, surface_area
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic [AXIS_BITS-1:0]     out_tuser   // long_axis
);

  logic    push_valid, push_ready;
  bounds_t push_data;
  logic    pop_valid, pop_ready;
  bounds_t pop_data;

  bbls_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bbls_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bbls_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/bbls_checker.sv
module bbls_checker
  import bbls_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic [AXIS_BITS-1:0]     out_tuser
);

  coord_t min_x, max_x, min_y, max_y, split;

  assign min_x = coord_t'(out_tdata[COORD_BITS-1:0]);
  assign max_x = coord_t'(out_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign min_y = coord_t'(out_tdata[3*COORD_BITS-1:2*COORD_BITS]);
  assign max_y = coord_t'(out_tdata[4*COORD_BITS-1:3*COORD_BITS]);
  assign split = coord_t'(out_tdata[7*COORD_BITS-1:6*COORD_BITS]);

  a_no_item_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("item offered right after reset");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled item dropped or changed");

  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> min_x <= max_x && min_y <= max_y)
    else $error("bounds out of order");

  a_area_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7*COORD_BITS])
    else $error("surface area odd");

  a_split_inside_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == AXIS_X |-> split >= min_x && split <= max_x)
    else $error("split outside x bounds");

endmodule

bind bounding_box_longest_axis_split_top bbls_checker u_bbls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
